// ===== rtl/czn_pkg.sv =====
// ----------------------------------------------------------------------------
// czn_pkg
// shared types and constants of the column z-score normalizer
// ----------------------------------------------------------------------------
package czn_pkg;

  localparam int MaxRows   = 65535;
  localparam int ValueBits = 24;
  localparam int CntW      = 16;
  localparam int SumW      = 40;
  localparam int SqW       = 64;
  localparam int PosMax    = 8388607;

  localparam logic KIND_ELEM  = 1'b0;
  localparam logic KIND_STATS = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [23:0] sample_value;
    logic               sample_missing;
    logic               last_row;
  } czn_in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [23:0] normalized_value;
    logic               value_missing;
    logic signed [23:0] center;
    logic        [22:0] scale;
  } czn_out_t;

  // classified job passed from front to back
  typedef struct packed {
    logic               is_stats;
    logic               missing;
    logic signed [23:0] sample;
    logic [CntW-1:0]    n;
    logic signed [SumW-1:0] sum;
    logic [SqW-1:0]     sq;
  } czn_job_t;

endpackage

// ===== rtl/column_zscore_normalizer.sv =====
// ----------------------------------------------------------------------------
// column_zscore_normalizer
// z-score standardization of a Q12.12 column streamed in two passes
// ----------------------------------------------------------------------------
// Accumulate beats are accepted while the queue has room and queue nothing
// but the last row. Each normalize beat is worked by a shared serial divider
// (one quotient bit a cycle); each column finish uses the same divider and a
// serial square root: up to four divisions, the multiply and sum states and
// the root. A normalize row skips the divider when missing or the scale is
// zero. A two-entry queue lets the front keep accepting while the back works;
// the front stalls only when two jobs wait in the queue.
module column_zscore_normalizer import czn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  czn_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output czn_out_t out_data
);

  logic               job_valid, job_ready;
  czn_job_t           job;

  czn_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid, .job_ready, .job
  );

  czn_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .out_data
  );

endmodule

// ===== rtl/czn_front.sv =====
// ----------------------------------------------------------------------------
// czn_front
// accepts beats, accumulates sums, emits jobs into a two-entry queue
// ----------------------------------------------------------------------------
module czn_front import czn_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  czn_in_t             in_data,
  output logic                job_valid,
  input  logic                job_ready,
  output czn_job_t            job
);

  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic [SqW-1:0]         sq_r, sq_nxt;
  czn_job_t               q_r [2];
  logic                   wp_r, rp_r;
  logic [1:0]             fill_r;
  logic                   acc, emit, pop;
  logic signed [23:0]     x;
  logic [23:0]            m;
  czn_job_t               nj;

  assign x   = in_data.sample_value;
  assign m   = x[23] ? 24'(-x) : 24'(x);
  assign in_ready = (fill_r != 2'd2);
  assign acc = in_valid && in_ready;
  assign emit = acc && (in_data.mode || in_data.last_row);
  assign pop = job_valid && job_ready;
  assign job_valid = (fill_r != 2'd0);
  assign job = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    if (acc && !in_data.mode && cnt_r != CntW'(MaxRows)) begin
      cnt_nxt = cnt_r + 1'b1;
      if (!in_data.sample_missing) begin
        sum_nxt = sum_r + SumW'(x);
        sq_nxt  = sq_r + SqW'(48'(m) * 48'(m));
      end
    end
    nj.is_stats = !in_data.mode;
    nj.missing  = in_data.sample_missing;
    nj.sample   = x;
    nj.n        = cnt_nxt;
    nj.sum      = sum_nxt;
    nj.sq       = sq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; sum_r <= '0; sq_r <= '0;
      wp_r <= 1'b0; rp_r <= 1'b0; fill_r <= '0;
    end else begin
      if (acc && !in_data.mode && in_data.last_row) begin
        cnt_r <= '0; sum_r <= '0; sq_r <= '0;
      end else begin
        cnt_r <= cnt_nxt; sum_r <= sum_nxt; sq_r <= sq_nxt;
      end
      if (emit) begin
        q_r[wp_r] <= nj;
        wp_r <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, emit} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 2'd2)
    else $error("queue overfill");
  a_nopush_full: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == 2'd2 |-> !acc) else $error("accept while full");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_data.mode && in_data.last_row |=> cnt_r == '0)
    else $error("accumulators not cleared");
`endif

endmodule

// ===== rtl/czn_back.sv =====
// ----------------------------------------------------------------------------
// czn_back
// serial divider and square root for statistics and normalize results
// ----------------------------------------------------------------------------
module czn_back import czn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  output logic     job_ready,
  input  czn_job_t job,
  output logic     out_valid,
  input  logic     out_ready,
  output czn_out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CDIV, S_QDIV, S_MUL, S_SUM, S_RDIV, S_VDIV, S_SQRT, S_NDIV, S_OUT
  } st_t;

  st_t                st_r;
  logic [5:0]         it_r;
  logic [SqW-1:0]     num_r, rem_r, quo_r, den_r;
  logic [SumW-1:0]    mag_r;
  logic               neg_r;
  logic [CntW-1:0]    n_r;
  logic [SqW-1:0]     sq_r, s_r, pp_r, t_r;
  logic [31:0]        q_r;
  logic [CntW-1:0]    r_r;
  logic signed [23:0] cen_r;
  logic [22:0]        scl_r;
  logic [SqW-1:0]     sres_r, sbit_r;
  czn_out_t           out_r;
  czn_out_t           head_out;
  logic [SqW:0]       trial;
  logic [SqW-1:0]     rsh, rnew, cq;
  logic [SqW:0]       sq_t;
  logic signed [24:0] diff;
  logic [24:0]        dmag;
  logic [SumW-1:0]    smag;

  assign job_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign rsh   = {rem_r[SqW-2:0], num_r[SqW-1]};
  assign trial = {1'b0, rsh} - {1'b0, den_r};
  assign rnew  = trial[SqW] ? rsh : trial[SqW-1:0];
  assign cq    = {quo_r[SqW-2:0], ~trial[SqW]};
  assign sq_t  = {1'b0, num_r} - {1'b0, sres_r} - {1'b0, sbit_r};
  assign diff  = 25'(job.sample) - 25'(cen_r);
  assign dmag  = diff[24] ? 25'(-diff) : 25'(diff);
  assign smag  = job.sum[SumW-1] ? SumW'(-job.sum) : SumW'(job.sum);

  always_comb begin
    head_out = '0;
    head_out.result_kind   = job.is_stats ? KIND_STATS : KIND_ELEM;
    head_out.value_missing = !job.is_stats && (scl_r != '0) && job.missing;
  end

  // statistics beats carry the stored center and scale
  always_comb begin
    out_data = out_r;
    if (out_r.result_kind == KIND_STATS) begin
      out_data.center = cen_r;
      out_data.scale  = scl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cen_r <= '0; scl_r <= '0; out_r <= '0;
      it_r <= '0; rem_r <= '0; quo_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            out_r <= head_out;
            it_r <= '0; rem_r <= '0; quo_r <= '0;
            if (job.is_stats) begin
              n_r <= job.n; sq_r <= job.sq;
              neg_r <= job.sum[SumW-1];
              mag_r <= smag;
              num_r <= SqW'(smag) + SqW'(job.n >> 1);
              den_r <= SqW'(job.n);
              if (job.n == '0) begin
                cen_r <= '0; scl_r <= '0;
                st_r <= S_OUT;
              end else begin
                st_r <= S_CDIV;
              end
            end else if (scl_r == '0 || job.missing) begin
              st_r <= S_OUT;
            end else begin
              neg_r <= diff[24];
              num_r <= SqW'({dmag, 12'd0}) + SqW'(scl_r >> 1);
              den_r <= SqW'(scl_r);
              st_r <= S_NDIV;
            end
          end
        end
        S_CDIV, S_QDIV, S_RDIV, S_VDIV, S_NDIV: begin
          if (it_r != 6'd63) begin
            num_r <= {num_r[SqW-2:0], 1'b0};
            rem_r <= rnew;
            quo_r <= cq;
            it_r  <= it_r + 1'b1;
          end else begin
            it_r <= '0; rem_r <= '0; quo_r <= '0;
            case (st_r)
              S_CDIV: begin
                cen_r <= neg_r ? 24'(-cq) : 24'(cq);
                if (n_r < CntW'(2)) begin
                  scl_r <= '0; st_r <= S_OUT;
                end else begin
                  num_r <= SqW'(mag_r); st_r <= S_QDIV;
                end
              end
              S_QDIV: begin
                q_r <= cq[31:0]; r_r <= rnew[CntW-1:0];
                st_r <= S_MUL;
              end
              S_RDIV: begin
                if (sq_r < s_r + cq) begin
                  scl_r <= '0; st_r <= S_OUT;
                end else begin
                  num_r <= sq_r - s_r - cq;
                  den_r <= SqW'(n_r - 1'b1);
                  st_r <= S_VDIV;
                end
              end
              S_VDIV: begin
                num_r <= cq; sres_r <= '0; sbit_r <= 64'h4000_0000_0000_0000;
                st_r <= S_SQRT;
              end
              default: begin
                if (neg_r) out_r.normalized_value <=
                  (cq > SqW'(PosMax + 1)) ? 24'h800000 : 24'(-cq);
                else out_r.normalized_value <=
                  (cq > SqW'(PosMax)) ? 24'h7fffff : 24'(cq);
                st_r <= S_OUT;
              end
            endcase
          end
        end
        S_MUL: begin
          // floor(sum^2/n) = q*q*n + 2qr + floor(r*r/n), q below 2^31
          pp_r  <= SqW'(q_r) * SqW'(q_r);
          t_r   <= (SqW'(q_r) * SqW'(r_r)) << 1;
          num_r <= SqW'(r_r) * SqW'(r_r);
          st_r  <= S_SUM;
        end
        S_SUM: begin
          s_r  <= pp_r * SqW'(n_r) + t_r;
          st_r <= S_RDIV;
        end
        S_SQRT: begin
          if (sbit_r == '0) begin
            scl_r <= (sres_r > SqW'(PosMax)) ? 23'h7fffff : 23'(sres_r);
            st_r <= S_OUT;
          end else begin
            if (!sq_t[SqW]) begin
              num_r <= sq_t[SqW-1:0];
              sres_r <= (sres_r >> 1) + sbit_r;
            end else sres_r <= sres_r >> 1;
            sbit_r <= sbit_r >> 2;
          end
        end
        S_OUT: begin
          if (out_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !job_ready) else $error("job taken while busy");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value_missing |-> out_data.normalized_value == '0)
    else $error("missing with value");
`endif

endmodule
